// ===== sv/dirscan_pkg.sv =====
package dirscan_pkg;

	localparam int unsigned MAX_SLOTS = 2048;
	localparam int unsigned SLOT_W    = 11;
	localparam int unsigned COUNT_W   = 16;

	localparam logic [7:0] BYTE_END      = 8'h00;
	localparam logic [7:0] BYTE_DELETED  = 8'hE5;
	localparam logic [7:0] BYTE_DOT      = 8'h2E;
	localparam logic [7:0] BYTE_SPACE    = 8'h20;
	localparam logic [7:0] ATTR_LONGNAME = 8'h0F;
	localparam logic [7:0] ATTR_VOLUME   = 8'h08;
	localparam logic [7:0] ATTR_DIR      = 8'h10;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		MODE_FIND  = 2'd0,
		MODE_FREE  = 2'd1,
		MODE_EMPTY = 2'd2,
		MODE_LIST  = 2'd3
	} scan_mode_t;

	typedef enum logic [1:0] {
		REG_SCAN_MODE   = 2'd0,
		REG_TARGET_BASE = 2'd1,
		REG_TARGET_EXT  = 2'd2,
		REG_LIST_LIMIT  = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		VERDICT_IGNORED   = 3'd0,
		VERDICT_SKIPPED   = 3'd1,
		VERDICT_LIVE      = 3'd2,
		VERDICT_MATCH     = 3'd3,
		VERDICT_FREE      = 3'd4,
		VERDICT_END       = 3'd5,
		VERDICT_NOT_EMPTY = 3'd6
	} verdict_t;

	typedef struct packed {
		scan_mode_t         scan_mode;
		logic [63:0]        target_name_base;
		logic [23:0]        target_name_ext;
		logic [COUNT_W-1:0] list_limit;
	} cfg_t;

	typedef struct packed {
		logic              new_scan;
		logic [SLOT_W-1:0] slot_index;
		logic [63:0]       entry_name_base;
		logic [23:0]       entry_name_ext;
		logic [7:0]        attribute;
		logic [31:0]       start_cluster;
		logic [31:0]       size_bytes;
	} entry_t;

	typedef struct packed {
		verdict_t           verdict;
		logic [SLOT_W-1:0]  slot_echo;
		logic               is_directory;
		logic [31:0]        cluster_echo;
		logic [31:0]        size_echo;
		logic [63:0]        listed_name_base;
		logic [23:0]        listed_name_ext;
		logic [COUNT_W-1:0] listed_total;
	} result_t;

	typedef struct packed {
		logic               finished;
		logic [COUNT_W-1:0] count;
	} scan_state_t;

endpackage

// ===== sv/dirscan_cfg.sv =====
module dirscan_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [63:0]         cfg_data,
	output dirscan_pkg::cfg_t   cfg
);
	import dirscan_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scan_mode        <= MODE_FIND;
			cfg_q.target_name_base <= 64'h2020_2020_2020_2020;
			cfg_q.target_name_ext  <= 24'h20_2020;
			cfg_q.list_limit       <= COUNT_MAX;
		end else if (cfg_valid) begin
			case (reg_index_t'(cfg_index))
				REG_SCAN_MODE:   cfg_q.scan_mode        <= scan_mode_t'(cfg_data[1:0]);
				REG_TARGET_BASE: cfg_q.target_name_base <= cfg_data;
				REG_TARGET_EXT:  cfg_q.target_name_ext  <= cfg_data[23:0];
				REG_LIST_LIMIT:  cfg_q.list_limit       <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/dirscan_classify.sv =====
module dirscan_classify (
	input  dirscan_pkg::cfg_t         cfg,
	input  dirscan_pkg::entry_t       entry,
	input  dirscan_pkg::scan_state_t  state_cur,
	output dirscan_pkg::scan_state_t  state_nxt,
	output dirscan_pkg::result_t      result
);
	import dirscan_pkg::*;

	logic [7:0]         first;
	logic [7:0]         b1;
	logic [7:0]         b2;
	logic               is_dot;
	logic               is_skip;
	logic               name_match;
	logic               fin0;
	logic [COUNT_W-1:0] cnt0;
	logic [COUNT_W-1:0] cnt_inc;
	verdict_t           verdict;

	always_comb begin
		first      = entry.entry_name_base[7:0];
		b1         = entry.entry_name_base[15:8];
		b2         = entry.entry_name_base[23:16];
		is_dot     = (first == BYTE_DOT) &&
			((b1 == BYTE_SPACE) || ((b1 == BYTE_DOT) && (b2 == BYTE_SPACE)));
		is_skip    = (first == BYTE_DELETED) || (entry.attribute == ATTR_LONGNAME) ||
			((entry.attribute & ATTR_VOLUME) != 8'h00);
		name_match = (entry.entry_name_base == cfg.target_name_base) &&
			(entry.entry_name_ext == cfg.target_name_ext);
		fin0       = entry.new_scan ? 1'b0 : state_cur.finished;
		cnt0       = entry.new_scan ? '0 : state_cur.count;
		cnt_inc    = (cnt0 != COUNT_MAX) ? cnt0 + 1'b1 : cnt0;

		state_nxt.finished = fin0;
		state_nxt.count    = cnt0;
		verdict            = VERDICT_SKIPPED;

		if (fin0) begin
			verdict = VERDICT_IGNORED;
		end else if ({1'b0, entry.slot_index} >= (SLOT_W+1)'(MAX_SLOTS)) begin
			verdict = VERDICT_SKIPPED;
		end else if (cfg.scan_mode == MODE_FREE) begin
			if ((first == BYTE_END) || (first == BYTE_DELETED)) begin
				verdict            = VERDICT_FREE;
				state_nxt.finished = 1'b1;
			end
		end else if ((cfg.scan_mode == MODE_LIST) && (cnt0 >= cfg.list_limit)) begin
			verdict            = VERDICT_IGNORED;
			state_nxt.finished = 1'b1;
		end else if (first == BYTE_END) begin
			verdict            = VERDICT_END;
			state_nxt.finished = 1'b1;
		end else if (is_skip) begin
			verdict = VERDICT_SKIPPED;
		end else begin
			case (cfg.scan_mode)
				MODE_FIND: begin
					if (name_match) begin
						verdict            = VERDICT_MATCH;
						state_nxt.finished = 1'b1;
					end else begin
						verdict = VERDICT_LIVE;
					end
				end
				MODE_EMPTY: begin
					if (is_dot) begin
						verdict = VERDICT_LIVE;
					end else begin
						verdict            = VERDICT_NOT_EMPTY;
						state_nxt.finished = 1'b1;
					end
				end
				MODE_LIST: begin
					verdict            = VERDICT_LIVE;
					state_nxt.count    = cnt_inc;
					state_nxt.finished = (cnt_inc >= cfg.list_limit);
				end
				default: verdict = VERDICT_SKIPPED;
			endcase
		end

		result.verdict          = verdict;
		result.slot_echo        = entry.slot_index;
		result.is_directory     = (entry.attribute & ATTR_DIR) != 8'h00;
		result.cluster_echo     = entry.start_cluster;
		result.size_echo        = entry.size_bytes;
		result.listed_name_base = entry.entry_name_base;
		result.listed_name_ext  = entry.entry_name_ext;
		result.listed_total     = state_nxt.count;
	end

endmodule

// ===== sv/dirscan_core.sv =====
module dirscan_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dirscan_pkg::cfg_t     cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  dirscan_pkg::entry_t   in_entry,
	output logic                  out_valid,
	input  logic                  out_ready,
	output dirscan_pkg::result_t  out_result
);
	import dirscan_pkg::*;

	logic        valid_s1;
	entry_t      entry_s1;
	logic        valid_s2;
	result_t     result_s2;
	scan_state_t state_q;
	scan_state_t state_nxt;
	result_t     result;
	logic        advance;

	assign advance    = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready   = !valid_s1 || advance;
	assign out_valid  = valid_s2;
	assign out_result = result_s2;

	dirscan_classify u_classify (
		.cfg       (cfg),
		.entry     (entry_s1),
		.state_cur (state_q),
		.state_nxt (state_nxt),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			entry_s1 <= in_entry;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

endmodule

// ===== sv/directory_entry_scanner_top.sv =====
// Directory entry scanner: classifies one 32-byte directory entry per beat.
// Entry beats arrive on the s_ channel (new_scan in s_tuser, the other entry
// fields in s_tdata) and one result beat per entry leaves on the m_ channel
// (verdict in m_tuser, echoes and listed_total in m_tdata).
// Registers are written through the cfg_ channel, which is always ready; they
// should only be changed while no entry is in flight.
// An accepted entry beat passes through the input register and then the
// result register before it leaves as a result beat. The scan state
// (done flag and live count) is updated as an entry moves into the result
// register, so while the receiver keeps m_tready high a new entry may be
// accepted on every cycle and throughput is one entry per cycle.
// When the receiver holds m_tready low, the result register keeps its beat;
// an empty input register still takes one more entry; s_tready is then low
// until the result is taken.
// Reset clears both stages, the done flag and the live count, and restores the
// register defaults: find mode, a target name of eleven spaces and a list
// limit of 65535.
module directory_entry_scanner_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// slot_index, entry_name_base, entry_name_ext, attribute, start_cluster,
	// size_bytes, zero pad
	input  logic [175:0] s_tdata,
	// new_scan
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// slot_echo, is_directory, cluster_echo, size_echo, listed_name_base,
	// listed_name_ext, listed_total, zero pad
	output logic [183:0] m_tdata,
	// verdict
	output logic [2:0]   m_tuser
);
	import dirscan_pkg::*;

	cfg_t    cfg;
	entry_t  in_entry;
	result_t out_result;

	assign in_entry.new_scan        = s_tuser;
	assign in_entry.slot_index      = s_tdata[10:0];
	assign in_entry.entry_name_base = s_tdata[74:11];
	assign in_entry.entry_name_ext  = s_tdata[98:75];
	assign in_entry.attribute       = s_tdata[106:99];
	assign in_entry.start_cluster   = s_tdata[138:107];
	assign in_entry.size_bytes      = s_tdata[170:139];

	assign m_tuser = out_result.verdict;
	assign m_tdata = {4'b0000,
		out_result.listed_total,
		out_result.listed_name_ext,
		out_result.listed_name_base,
		out_result.size_echo,
		out_result.cluster_echo,
		out_result.is_directory,
		out_result.slot_echo};

	dirscan_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dirscan_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_entry   (in_entry),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (out_result)
	);

endmodule

// ===== sv/dirscan_checker.sv =====
module dirscan_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [183:0] m_tdata,
	input logic [2:0]   m_tuser
);
	import dirscan_pkg::*;

	// A stalled result beat keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// An accepted entry reaches the result register once it sits in the input register and the output can move.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 (!m_tvalid || m_tready) |=> m_tvalid)
		else $error("accepted entry did not reach the result register");

	// A free verdict is only given to an unused or deleted slot.
	a_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == VERDICT_FREE) |->
		(m_tdata[83:76] == BYTE_END) || (m_tdata[83:76] == BYTE_DELETED))
		else $error("free verdict on a used slot");

	// An end verdict is only given to an entry whose first name byte is zero.
	a_end_mark: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == VERDICT_END) |-> (m_tdata[83:76] == BYTE_END))
		else $error("end verdict without an end mark");

endmodule

bind directory_entry_scanner_top dirscan_checker u_dirscan_checker (.*);
